// ===== hw/rtl/pfe_pkg.sv =====
// shared types, constants and decode helpers for the postfix expression evaluator
package pfe_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_MUL   = 8'h2A;
  localparam logic [7:0] SYM_DIV   = 8'h2F;
  localparam logic [7:0] SYM_ZERO  = 8'h30;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } pfe_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               overflow_seen;
    logic               underflow_seen;
    logic               divide_by_zero_seen;
  } pfe_out_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
    logic              divzero;
  } alu_rsp_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [DATA_W-1:0] data;
  } stk_cmd_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] pop_data;
  } stk_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_B,
    ST_POP_A,
    ST_EXEC,
    ST_WAIT,
    ST_POP_R,
    ST_LOAD_R
  } pfe_state_t;

  function automatic logic is_operator(input logic [7:0] sym);
    return (sym == SYM_PLUS) || (sym == SYM_MINUS) || (sym == SYM_MUL) || (sym == SYM_DIV);
  endfunction

  function automatic alu_op_t sym_to_op(input logic [7:0] sym);
    alu_op_t op;
    unique case (sym)
      SYM_PLUS:  op = ALU_ADD;
      SYM_MINUS: op = ALU_SUB;
      SYM_MUL:   op = ALU_MUL;
      default:   op = ALU_DIV;
    endcase
    return op;
  endfunction

endpackage

// ===== hw/rtl/pfe_stack.sv =====
// bounded value stack: memory with registered pop data and an entry count
module pfe_stack
  import pfe_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  stk_cmd_t  cmd,
  output stk_stat_t stat
);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic              pop_empty;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_m1;
  logic              empty;
  logic              full;

  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(STACK_DEPTH));
  assign count_m1 = count - CNT_W'(1);

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[count[PTR_W-1:0]] <= cmd.data;
    end
    if (cmd.pop) begin
      rd_q      <= mem[count_m1[PTR_W-1:0]];
      pop_empty <= empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.push && !full) begin
      count <= count + CNT_W'(1);
    end else if (cmd.pop && !empty) begin
      count <= count_m1;
    end
  end

  // a pop of an empty stack gives all ones
  assign stat.empty    = empty;
  assign stat.full     = full;
  assign stat.count    = count;
  assign stat.pop_data = pop_empty ? '1 : rd_q;

endmodule

// ===== hw/rtl/pfe_alu.sv =====
// shared arithmetic unit: registered add, subtract, multiply; radix-2 divider
module pfe_alu
  import pfe_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic                 busy;
  logic                 fix;
  logic                 done;
  logic                 div_go;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DATA_W-1:0]    result;
  logic                 divzero;
  logic                 neg;
  logic [DATA_W-1:0]    divisor;
  logic [DATA_W-1:0]    rem;
  logic [DATA_W-1:0]    quo;
  logic [DATA_W:0]      rem_shift;
  logic [DATA_W:0]      trial;
  logic [DATA_W-1:0]    mag_a;
  logic [DATA_W-1:0]    mag_b;

  assign mag_a     = req.a[DATA_W-1] ? (DATA_W'(0) - req.a) : req.a;
  assign mag_b     = req.b[DATA_W-1] ? (DATA_W'(0) - req.b) : req.b;
  assign rem_shift = {rem, quo[DATA_W-1]};
  assign trial     = rem_shift - {1'b0, divisor};
  // a division with a nonzero divisor runs the iterative loop
  assign div_go    = req.start && (req.op == ALU_DIV) && (req.b != '0);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= (req.start && !div_go) || (!req.start && !busy && fix);
      fix  <= !req.start && busy && (cnt == '1);
      if (req.start) begin
        if (div_go) begin
          busy <= 1'b1;
          cnt  <= '0;
        end
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == '1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      divzero <= (req.op == ALU_DIV) && (req.b == '0);
      unique case (req.op)
        ALU_ADD: result <= req.a + req.b;
        ALU_SUB: result <= req.a - req.b;
        ALU_MUL: result <= req.a * req.b;
        ALU_DIV: begin
          if (req.b == '0) begin
            result <= '0;
          end
          neg     <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
          divisor <= mag_b;
          rem     <= '0;
          quo     <= mag_a;
        end
      endcase
    end else if (busy) begin
      // one quotient bit per cycle, restoring
      if (!trial[DATA_W]) begin
        rem <= trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end else if (fix) begin
      result <= neg ? (DATA_W'(0) - quo) : quo;
    end
  end

  assign rsp.done    = done;
  assign rsp.result  = result;
  assign rsp.divzero = divzero;

endmodule

// ===== hw/rtl/postfix_expression_evaluator.sv =====
// top level: request sequencer, sticky flags and result register of the postfix evaluator
//
// Postfix (reverse Polish) evaluator. Each request carries one expression
// character; '+', '-', '*' and '/' pop the right and then the left operand and
// push the wrapped 32-bit result (truncating quotient), any other character
// pushes its code minus '0'. A request with last_symbol set also pops the top
// and delivers it with the overflow, underflow and divide-by-zero flags, which
// then clear. An operand is pushed when it is taken; +, - and * pop twice
// (through the registered stack read port), pass through the shared arithmetic
// unit and then push; / goes through the shared radix-2 divider, which
// produces one quotient bit per cycle and then applies a sign fix.
// A final character adds the closing pop and the result load.
// The block takes one request at a time; a finished result waits in its
// output register while the next request is taken, and the load of a new
// result waits only while the previous one is still untaken. The stack
// memory needs no clearing pass after reset.
module postfix_expression_evaluator
  import pfe_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  pfe_in_t  item,
  output logic     result_valid,
  input  logic     result_ready,
  output pfe_out_t result
);

  pfe_state_t        state;
  pfe_state_t        state_next;
  stk_cmd_t          stk_cmd;
  stk_stat_t         stk_stat;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;

  logic              accept;
  logic              item_is_op;
  logic              load_out;
  logic              out_free;
  logic              last_q;
  alu_op_t           op_q;
  logic [DATA_W-1:0] rhs_q;
  logic              overflow_flag;
  logic              underflow_flag;
  logic              divzero_flag;
  logic              overflow_next;
  logic              underflow_next;
  logic              divzero_next;

  pfe_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (stk_cmd),
    .stat (stk_stat)
  );

  pfe_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign accept     = item_valid && item_ready;
  assign item_is_op = is_operator(item.symbol);
  assign out_free   = !result_valid || result_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item_is_op) begin
            state_next = ST_POP_B;
          end else if (item.last_symbol) begin
            state_next = ST_POP_R;
          end
        end
      end
      ST_POP_B: state_next = ST_POP_A;
      ST_POP_A: state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_WAIT;
      ST_WAIT: begin
        if (alu_rsp.done) begin
          state_next = last_q ? ST_POP_R : ST_IDLE;
        end
      end
      ST_POP_R:  state_next = ST_LOAD_R;
      ST_LOAD_R: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_ready    = 1'b0;
    stk_cmd.push  = 1'b0;
    stk_cmd.pop   = 1'b0;
    stk_cmd.data  = alu_rsp.result;
    alu_req.start = 1'b0;
    alu_req.op    = op_q;
    alu_req.a     = stk_stat.pop_data;
    alu_req.b     = rhs_q;
    load_out      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready   = 1'b1;
        // operands go straight onto the stack
        stk_cmd.push = item_valid && !item_is_op;
        stk_cmd.data = {24'b0, item.symbol} - {24'b0, SYM_ZERO};
      end
      ST_POP_B: stk_cmd.pop = 1'b1;
      ST_POP_A: stk_cmd.pop = 1'b1;
      ST_EXEC:  alu_req.start = 1'b1;
      ST_WAIT:  stk_cmd.push = alu_rsp.done;
      ST_POP_R: stk_cmd.pop = 1'b1;
      ST_LOAD_R: load_out = out_free;
      default: begin
      end
    endcase
  end

  // sticky flags; cleared once a result has taken them
  always_comb begin
    overflow_next  = overflow_flag  || (stk_cmd.push && stk_stat.full);
    underflow_next = underflow_flag || (stk_cmd.pop && stk_stat.empty);
    divzero_next   = divzero_flag   || (state == ST_WAIT && alu_rsp.done && alu_rsp.divzero);
    if (load_out) begin
      overflow_next  = 1'b0;
      underflow_next = 1'b0;
      divzero_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      overflow_flag  <= 1'b0;
      underflow_flag <= 1'b0;
      divzero_flag   <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      state          <= state_next;
      overflow_flag  <= overflow_next;
      underflow_flag <= underflow_next;
      divzero_flag   <= divzero_next;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // request fields and operands held during the operation
  always_ff @(posedge clk) begin
    if (accept) begin
      last_q <= item.last_symbol;
      op_q   <= sym_to_op(item.symbol);
    end
    if (state == ST_POP_A) begin
      rhs_q <= stk_stat.pop_data;
    end
    if (load_out) begin
      result.result_value        <= stk_stat.pop_data;
      result.overflow_seen       <= overflow_flag;
      result.underflow_seen      <= underflow_flag;
      result.divide_by_zero_seen <= divzero_flag;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stk_stat.count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(stk_cmd.push && stk_cmd.pop))
    else $error("stack push and pop in one cycle");

  a_alu_done_wait: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> state == ST_WAIT)
    else $error("arithmetic unit finished outside the wait state");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> result_valid)
    else $error("loaded result not presented");
`endif

endmodule
